### rtl/core/dmd_pkg.sv
// dmd_pkg: shared constants and types for the depth map to distance converter
// no dependencies; used by dmd_div and depth_map_to_distance
`default_nettype none

package dmd_pkg;

    // default widths of the pixel and the distance words
    localparam int PIXEL_BITS_DEF = 8;
    localparam int DIST_BITS_DEF  = 32;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_NEAR = 1'b0,
        REG_FAR  = 1'b1
    } t_reg_idx;

endpackage

`default_nettype wire

### rtl/core/dmd_div.sv
// dmd_div: pipelined restoring divider, one quotient bit per stage
// depends on dmd_pkg for default widths
`default_nettype none

module dmd_div #(
    parameter int PIXEL_BITS = dmd_pkg::PIXEL_BITS_DEF,
    parameter int DIST_BITS  = dmd_pkg::DIST_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [2*DIST_BITS+PIXEL_BITS-1:0]   i_num,
    input  wire logic [PIXEL_BITS+DIST_BITS:0]       i_den,
    input  wire logic                                i_zero,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [DIST_BITS-1:0]                     o_distance
);

    localparam int DB = DIST_BITS;
    localparam int DW = PIXEL_BITS + DIST_BITS + 1;
    localparam int NW = 2 * DIST_BITS + PIXEL_BITS;

    logic          r_v    [0:DB];
    logic [DW-1:0] r_rem  [0:DB];
    logic [DW-1:0] r_den  [0:DB];
    logic [DB-1:0] r_lo   [0:DB];
    logic [DB-1:0] r_q    [0:DB];
    logic          r_zero [0:DB];
    logic          w_rdy  [0:DB+1];

    // ready chain, bubbles close up behind a stalled output
    assign w_rdy[DB+1] = ~i_stall;
    generate
        for (genvar j = 0; j <= DB; j++) begin : g_rdy
            assign w_rdy[j] = ~r_v[j] | w_rdy[j+1];
        end
    endgenerate

    assign o_ready = w_rdy[0];

    // stage 0: high part of the numerator is the first partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
        if (w_rdy[0] && i_valid) begin
            r_rem[0]  <= DW'(i_num[NW-1:DB]);
            r_lo[0]   <= i_num[DB-1:0];
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_zero[0] <= i_zero;
        end
    end

    // stages 1..DB: shift in one numerator bit, trial subtract
    generate
        for (genvar j = 1; j <= DB; j++) begin : g_stage
            logic [DW:0] w_sh;
            logic [DW:0] w_diff;
            logic        w_ge;

            always_comb begin
                w_sh   = {r_rem[j-1], r_lo[j-1][DB-1]};
                w_diff = w_sh - {1'b0, r_den[j-1]};
                w_ge   = ~w_diff[DW];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
                if (w_rdy[j] && r_v[j-1]) begin
                    r_rem[j]  <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                    r_lo[j]   <= r_lo[j-1] << 1;
                    r_den[j]  <= r_den[j-1];
                    r_q[j]    <= {r_q[j-1][DB-2:0], w_ge};
                    r_zero[j] <= r_zero[j-1];
                end
            end
        end
    endgenerate

    // zero divisor reads as the largest distance
    assign o_valid    = r_v[DB];
    assign o_distance = r_zero[DB] ? {DB{1'b1}} : r_q[DB];

endmodule

`default_nettype wire

### rtl/core/depth_map_to_distance.sv
// depth_map_to_distance: depth map intensity to Q16.16 scene distance
// depends on dmd_pkg and dmd_div
//
//   channel   direction  handshake                 payload
//   pixel     in         i_valid / o_stall         i_intensity
//   distance  out        o_valid / i_stall         o_distance
//   config    in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one word per cycle sustained while i_stall is low; three multiply and
// add stages, then one divider stage per quotient bit plus a load stage.
// synchronous reset clears all valid bits and loads near 1.0, far 100.0.
// a stalled output holds its word; stages behind it keep filling bubbles
// until the pipe is full, then o_stall rises.
`default_nettype none

module depth_map_to_distance #(
    parameter int PIXEL_BITS = dmd_pkg::PIXEL_BITS_DEF,
    parameter int DIST_BITS  = dmd_pkg::DIST_BITS_DEF,
    localparam int STRIDE_LG = (DIST_BITS > 32) ? 3 : 2,
    localparam int ADDR_W    = STRIDE_LG + 1,
    localparam int DATA_W    = (DIST_BITS > 32) ? 64 : 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIXEL_BITS-1:0] i_intensity,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DIST_BITS-1:0]       o_distance,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    localparam int PB  = PIXEL_BITS;
    localparam int DB  = DIST_BITS;
    localparam int LO  = DB / 2;
    localparam int HI  = DB - LO;
    localparam int PDW = PB + DB;
    localparam int DW  = PB + DB + 1;
    localparam int PW  = 2 * DB;
    localparam int NW  = 2 * DB + PB;
    localparam logic [PB-1:0] PIX_MAX = {PB{1'b1}};
    localparam logic [DB-1:0] NEAR_RST = DB'(65536);
    localparam logic [DB-1:0] FAR_RST  = DB'(6553600);

    logic [DB-1:0] r_near;
    logic [DB-1:0] r_far;
    dmd_pkg::t_reg_idx w_idx;

    // register file
    assign pready = 1'b1;
    assign w_idx  = dmd_pkg::t_reg_idx'(paddr[ADDR_W-1:STRIDE_LG]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RST;
            r_far  <= FAR_RST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                dmd_pkg::REG_NEAR: r_near <= pwdata[DB-1:0];
                dmd_pkg::REG_FAR:  r_far  <= pwdata[DB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            dmd_pkg::REG_NEAR: prdata = DATA_W'(r_near);
            dmd_pkg::REG_FAR:  prdata = DATA_W'(r_far);
            default:           prdata = '0;
        endcase
    end

    // front pipeline handshake
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3, w_div_rdy;

    assign w_rdy3  = ~r_v3 | w_div_rdy;
    assign w_rdy2  = ~r_v2 | w_rdy3;
    assign w_rdy1  = ~r_v1 | w_rdy2;
    assign o_stall = ~w_rdy1;

    // stage 1: partial products of near*far, and the two divisor terms
    logic [2*LO-1:0]  r1_p00;
    logic [LO+HI-1:0] r1_p01, r1_p10;
    logic [2*HI-1:0]  r1_p11;
    logic [PDW-1:0]   r1_a, r1_b;
    logic [LO-1:0]    w_zn_lo, w_zf_lo;
    logic [HI-1:0]    w_zn_hi, w_zf_hi;

    assign w_zn_lo = r_near[LO-1:0];
    assign w_zn_hi = r_near[DB-1:LO];
    assign w_zf_lo = r_far[LO-1:0];
    assign w_zf_hi = r_far[DB-1:LO];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (w_rdy1 && i_valid) begin
            r1_p00 <= (2*LO)'(w_zn_lo) * (2*LO)'(w_zf_lo);
            r1_p01 <= (LO+HI)'(w_zn_lo) * (LO+HI)'(w_zf_hi);
            r1_p10 <= (LO+HI)'(w_zn_hi) * (LO+HI)'(w_zf_lo);
            r1_p11 <= (2*HI)'(w_zn_hi) * (2*HI)'(w_zf_hi);
            r1_a   <= PDW'(i_intensity) * PDW'(r_far);
            r1_b   <= PDW'(PIX_MAX - i_intensity) * PDW'(r_near);
        end
    end

    // stage 2: full plane product, divisor sum
    logic [PW-1:0] r2_p;
    logic [DW-1:0] r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2 && r_v1) begin
            r2_p   <= (PW'(r1_p11) << (2*LO)) + ((PW'(r1_p01) + PW'(r1_p10)) << LO)
                      + PW'(r1_p00);
            r2_den <= DW'(r1_a) + DW'(r1_b);
        end
    end

    // stage 3: numerator times the full-scale intensity, zero divisor flag
    logic [NW-1:0] r3_num;
    logic [DW-1:0] r3_den;
    logic          r3_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
        if (w_rdy3 && r_v2) begin
            r3_num  <= (NW'(r2_p) << PB) - NW'(r2_p);
            r3_den  <= r2_den;
            r3_zero <= (r2_den == '0);
        end
    end

    // quotient pipeline
    dmd_div #(
        .PIXEL_BITS (PIXEL_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .o_ready    (w_div_rdy),
        .i_num      (r3_num),
        .i_den      (r3_den),
        .i_zero     (r3_zero),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance)
    );

endmodule

`default_nettype wire

### test/depth_map_to_distance_chk.sv
// depth_map_to_distance_chk: watches the pixel, distance and config channels of the converter
// predicts each distance word from the mirrored planes and compares in order
// depends on dmd_pkg
module depth_map_to_distance_chk #(
    parameter int PIXEL_BITS = dmd_pkg::PIXEL_BITS_DEF,
    parameter int DIST_BITS  = dmd_pkg::DIST_BITS_DEF,
    parameter int ADDR_W     = 3,
    parameter int DATA_W     = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  o_stall,
    input  wire logic [PIXEL_BITS-1:0] i_intensity,
    input  wire logic                  o_valid,
    input  wire logic                  i_stall,
    input  wire logic [DIST_BITS-1:0]  o_distance,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    input  wire logic                  pready,
    output int                         fail_count,
    output int                         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // wide enough for the full numerator and denominator
    localparam int PROD_W = 2 * DIST_BITS + PIXEL_BITS + 1;
    localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;

    logic [DIST_BITS-1:0] near_q;
    logic [DIST_BITS-1:0] far_q;
    logic [DIST_BITS-1:0] distance_q[$];
    logic [DIST_BITS-1:0] want;

    initial begin
        fail_count = 0;
    end

    // inverse-depth interpolation, zero divisor gives the farthest value
    function automatic logic [DIST_BITS-1:0] predict_distance(
        input logic [PIXEL_BITS-1:0] d,
        input logic [DIST_BITS-1:0]  zn,
        input logic [DIST_BITS-1:0]  zf
    );
        logic [PROD_W-1:0] wd, wrest, wmax, wn, wf, num, den, quo;
        wd    = d;
        wrest = PIXEL_MAX - d;
        wmax  = PIXEL_MAX;
        wn    = zn;
        wf    = zf;
        den   = wd * wf + wrest * wn;
        num   = wmax * wn * wf;
        if (den == '0) begin
            quo = '1;
        end else begin
            quo = num / den;
        end
        return quo[DIST_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [DIST_BITS-1:0] got,
                                   input logic [DIST_BITS-1:0] expd);
        $display("mismatch at %0t: %s, got %h expected %h", $realtime, what, got, expd);
        fail_count++;
    endtask

    // compare results first so a word with nothing queued is caught, then predict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            near_q        <= DIST_BITS'(65536);
            far_q         <= DIST_BITS'(6553600);
            pending_count <= 0;
            distance_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (distance_q.size() == 0) begin
                    report_mismatch("distance word with none expected", o_distance, '0);
                end else begin
                    want = distance_q.pop_front();
                    if (o_distance !== want) begin
                        report_mismatch("distance", o_distance, want);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                distance_q.push_back(predict_distance(i_intensity, near_q, far_q));
            end
            // mirror of the plane registers
            if (psel && penable && pwrite && pready) begin
                case (dmd_pkg::t_reg_idx'(paddr[ADDR_W-1]))
                    dmd_pkg::REG_NEAR: near_q <= pwdata[DIST_BITS-1:0];
                    dmd_pkg::REG_FAR:  far_q  <= pwdata[DIST_BITS-1:0];
                    default: ;
                endcase
            end
            pending_count <= distance_q.size();
        end
    end

endmodule

### test/depth_map_to_distance_tb.sv
// depth_map_to_distance_tb: drives pixels and plane settings into the converter, gives the verdict
// depends on dmd_pkg, depth_map_to_distance and depth_map_to_distance_chk
module depth_map_to_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_BITS  = dmd_pkg::PIXEL_BITS_DEF;
    localparam int DIST_BITS   = dmd_pkg::DIST_BITS_DEF;
    localparam int ADDR_W      = (DIST_BITS > 32) ? 4 : 3;
    localparam int DATA_W      = (DIST_BITS > 32) ? 64 : 32;
    localparam int LATENCY     = DIST_BITS + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BLOCK_WORDS = 125;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_stall     = 1'b0;
    logic [PIXEL_BITS-1:0] i_intensity = '0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [ADDR_W-1:0]     paddr       = '0;
    logic [DATA_W-1:0]     pwdata      = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [DIST_BITS-1:0]  o_distance;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    int tx_idle_pct  = 14;
    int rx_stall_pct = 77;
    int fail_count;
    int pending_count;
    int cycle_count  = 0;

    depth_map_to_distance #(
        .PIXEL_BITS(PIXEL_BITS),
        .DIST_BITS (DIST_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_intensity(i_intensity),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    depth_map_to_distance_chk #(
        .PIXEL_BITS(PIXEL_BITS),
        .DIST_BITS (DIST_BITS),
        .ADDR_W    (ADDR_W),
        .DATA_W    (DATA_W)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_intensity  (i_intensity),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_distance   (o_distance),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // one pixel word, with random idle cycles ahead of it
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] d);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_intensity <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // hold off until every predicted distance has come out
    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // apb write, setup then access
    task automatic write_plane(input dmd_pkg::t_reg_idx idx, input logic [DIST_BITS-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {(ADDR_W-1){1'b0}}};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_planes(input logic [DIST_BITS-1:0] zn, input logic [DIST_BITS-1:0] zf);
        write_plane(dmd_pkg::REG_NEAR, zn);
        write_plane(dmd_pkg::REG_FAR, zf);
    endtask

    // mix of full range, small, realistic, inverted and equal planes
    task automatic pick_planes(output logic [DIST_BITS-1:0] zn, output logic [DIST_BITS-1:0] zf);
        logic [DIST_BITS-1:0] a;
        logic [DIST_BITS-1:0] b;
        case ($urandom_range(0, 4))
            0: begin
                a = $urandom();
                b = $urandom();
            end
            1: begin
                a = $urandom_range(1, 32'h0004_0000);
                b = a + $urandom_range(0, 32'h00FF_FFFF);
            end
            2: begin
                a = $urandom_range(32'h0000_1000, 32'h0004_0000);
                b = $urandom_range(a, 32'h7FFF_FFFF);
            end
            3: begin
                b = $urandom_range(1, 32'h0100_0000);
                a = b + $urandom_range(1, 32'h7FFF_FFFF);
            end
            default: begin
                a = $urandom();
                b = a;
            end
        endcase
        zn = a;
        zf = b;
    endtask

    function automatic logic [PIXEL_BITS-1:0] random_intensity();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_BITS'($urandom());
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        logic [DIST_BITS-1:0] near_set[6];
        logic [DIST_BITS-1:0] far_set[6];
        logic [DIST_BITS-1:0] zn;
        logic [DIST_BITS-1:0] zf;

        // extremes, inverted planes, zero planes with and without a zero divisor
        near_set = '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                     32'h0001_0000, 32'h0000_0000};
        far_set  = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0064_0000,
                     32'h0000_0000, 32'h0000_0000};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset planes: ends of the range and alternating bits
        send_pixel('0);
        send_pixel('1);
        send_pixel(PIXEL_BITS'(1));
        send_pixel(PIXEL_BITS'(254));
        send_pixel(PIXEL_BITS'(8'h55));
        send_pixel(PIXEL_BITS'(8'hAA));

        for (int s = 0; s < 6; s++) begin
            set_planes(near_set[s], far_set[s]);
            send_pixel('0);
            send_pixel('1);
            send_pixel(random_intensity());
        end

        // random part under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct  = 14;
                    rx_stall_pct = 77;
                end
                1: begin
                    tx_idle_pct  = 77;
                    rx_stall_pct = 14;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                pick_planes(zn, zf);
                set_planes(zn, zf);
                for (int n = 0; n < BLOCK_WORDS; n++) begin
                    if (n == 60 || $urandom_range(0, 199) == 0) begin
                        drain_results();
                    end
                    send_pixel(random_intensity());
                end
            end
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
